>>> hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

  // Store geometry.
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned OCC_W  = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  // Command kinds.
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_LIST   = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_POPPED    = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_REMOVED   = 3'd5;
  localparam logic [2:0] ST_NOT_FOUND = 3'd6;
  localparam logic [2:0] ST_LISTED    = 3'd7;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [63:0] payload;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] key_id;
    logic [7:0]  prio;
    logic [63:0] payload;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] id;
    logic [7:0]  prio;
    logic [63:0] payload;
    logic        last;
  } res_t;

endpackage

>>> hw/rtl/spq_if.sv
`timescale 1ns / 1ps

// Request channel into the queue.
interface spq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] key_id;
  logic [7:0]  priority_req;
  logic [63:0] payload;

  modport source (output valid, kind, key_id, priority_req, payload, input ready);
  modport sink   (input valid, kind, key_id, priority_req, payload, output ready);
endinterface

// Result channel out of the queue.
interface spq_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] out_id;
  logic [7:0]  out_priority;
  logic [63:0] out_payload;
  logic        last;

  modport source (output valid, status, out_id, out_priority, out_payload, last, input ready);
  modport sink   (input valid, status, out_id, out_priority, out_payload, last, output ready);
endinterface

>>> hw/rtl/spq_ram.sv
`timescale 1ns / 1ps

// Entry store: one write port, one read port with registered data.
module spq_ram
  import spq_pkg::*;
(
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  entry_t            wr_data_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output entry_t            rd_data_o
);

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/sorted_priority_queue_unique_keys.sv
`timescale 1ns / 1ps

// Sorted priority queue holding up to DEPTH entries of id, priority and payload,
// kept in descending priority order with first in, first out order among equal
// priorities. Commands arrive as requests on req_i (valid/ready); every request
// produces one result on rsp_o, except a list of a non-empty store, which
// produces one result per entry, head first, with last set on the final one.
// The block takes one request at a time: ready is high only while the
// sequencer is idle. Entries live in a single-port-read memory, so every
// stored entry visited takes an address step, then a registered-data step.
// Insert walks the entries for the duplicate check until a match or the end,
// then moves the entries behind the insertion point down one slot. Pop and
// remove move the tail up one slot in the same way; list reads each entry in turn.
// Results pass through an output register, so a new request is accepted while
// the previous result still waits; if the receiver stalls, the sequencer holds
// at its next result until the register is free. Reset empties the queue
// (the occupancy count clears); memory contents are not cleared.
module sorted_priority_queue_unique_keys
  import spq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_req_if.sink    req_i,
  spq_rsp_if.source  rsp_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CHK = 4'd2;
  localparam logic [3:0] S_INS_CHK  = 4'd3;
  localparam logic [3:0] S_SD_CHK   = 4'd4;
  localparam logic [3:0] S_SD_WR    = 4'd5;
  localparam logic [3:0] S_POP_RD   = 4'd6;
  localparam logic [3:0] S_POP_CAP  = 4'd7;
  localparam logic [3:0] S_SU_CHK   = 4'd8;
  localparam logic [3:0] S_SU_WR    = 4'd9;
  localparam logic [3:0] S_LIST_RD  = 4'd10;
  localparam logic [3:0] S_LIST_OUT = 4'd11;
  localparam logic [3:0] S_EMIT     = 4'd12;

  localparam logic [OCC_W-1:0] OCC_ONE  = OCC_W'(1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

  logic [3:0]       state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic [OCC_W-1:0] idx_q, idx_d;
  logic [OCC_W-1:0] pos_q, pos_d;
  logic             pos_found_q, pos_found_d;
  res_t             st_q, st_d;
  res_t             out_q, out_d;
  logic             out_valid_q;
  logic             load_out;

  logic [OCC_W-1:0]  idx_inc, idx_dec;
  logic              slot_free;
  logic              id_hit, prio_below;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  entry_t            wr_data, rd_data;

  spq_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign idx_inc   = idx_q + OCC_ONE;
  assign idx_dec   = idx_q - OCC_ONE;
  assign slot_free = !out_valid_q || rsp_o.ready;

  // The shared compare unit: one stored entry against the command per step.
  assign id_hit     = (rd_data.id == cmd_q.key_id);
  assign prio_below = (rd_data.prio < cmd_q.prio);

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    occ_d       = occ_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    pos_found_d = pos_found_q;
    st_d        = st_q;
    out_d       = st_q;
    load_out    = 1'b0;
    rd_addr     = idx_q[ADDR_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = idx_q[ADDR_W-1:0];
    wr_data     = rd_data;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          cmd_d       = '{kind: req_i.kind, key_id: req_i.key_id,
                          prio: req_i.priority_req, payload: req_i.payload};
          idx_d       = '0;
          pos_d       = occ_q;
          pos_found_d = 1'b0;
          case (req_i.kind)
            KIND_INSERT: begin
              state_d = (occ_q == '0) ? S_INS_CHK : S_SCAN_RD;
            end
            KIND_POP: begin
              if (occ_q == '0) begin
                st_d    = '{status: ST_EMPTY, id: '0, prio: '0, payload: '0, last: 1'b1};
                state_d = S_EMIT;
              end else begin
                state_d = S_POP_RD;
              end
            end
            KIND_REMOVE: begin
              if (occ_q == '0) begin
                st_d    = '{status: ST_NOT_FOUND, id: req_i.key_id, prio: '0,
                            payload: '0, last: 1'b1};
                state_d = S_EMIT;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            default: begin
              if (occ_q == '0) begin
                st_d    = '{status: ST_EMPTY, id: '0, prio: '0, payload: '0, last: 1'b1};
                state_d = S_EMIT;
              end else begin
                state_d = S_LIST_RD;
              end
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (id_hit) begin
          if (cmd_q.kind == KIND_INSERT) begin
            st_d    = '{status: ST_DUPLICATE, id: cmd_q.key_id, prio: '0,
                        payload: '0, last: 1'b1};
            state_d = S_EMIT;
          end else begin
            // Removal point found: close the gap from here.
            st_d    = '{status: ST_REMOVED, id: cmd_q.key_id, prio: '0,
                        payload: '0, last: 1'b1};
            state_d = S_SU_CHK;
          end
        end else begin
          if (!pos_found_q && prio_below) begin
            pos_d       = idx_q;
            pos_found_d = 1'b1;
          end
          if (idx_inc == occ_q) begin
            if (cmd_q.kind == KIND_INSERT) begin
              state_d = S_INS_CHK;
            end else begin
              st_d    = '{status: ST_NOT_FOUND, id: cmd_q.key_id, prio: '0,
                          payload: '0, last: 1'b1};
              state_d = S_EMIT;
            end
          end else begin
            idx_d   = idx_inc;
            state_d = S_SCAN_RD;
          end
        end
      end
      S_INS_CHK: begin
        if (occ_q == OCC_FULL) begin
          st_d    = '{status: ST_FULL, id: cmd_q.key_id, prio: '0, payload: '0, last: 1'b1};
          state_d = S_EMIT;
        end else begin
          idx_d   = occ_q;
          state_d = S_SD_CHK;
        end
      end
      S_SD_CHK: begin
        if (idx_q == pos_q) begin
          wr_en   = 1'b1;
          wr_data = '{id: cmd_q.key_id, prio: cmd_q.prio, payload: cmd_q.payload};
          occ_d   = occ_q + OCC_ONE;
          st_d    = '{status: ST_ADDED, id: cmd_q.key_id, prio: '0, payload: '0, last: 1'b1};
          state_d = S_EMIT;
        end else begin
          rd_addr = idx_dec[ADDR_W-1:0];
          state_d = S_SD_WR;
        end
      end
      S_SD_WR: begin
        wr_en   = 1'b1;
        idx_d   = idx_dec;
        state_d = S_SD_CHK;
      end
      S_POP_RD: begin
        state_d = S_POP_CAP;
      end
      S_POP_CAP: begin
        st_d    = '{status: ST_POPPED, id: rd_data.id, prio: rd_data.prio,
                    payload: rd_data.payload, last: 1'b1};
        state_d = S_SU_CHK;
      end
      S_SU_CHK: begin
        if (idx_inc < occ_q) begin
          rd_addr = idx_inc[ADDR_W-1:0];
          state_d = S_SU_WR;
        end else begin
          occ_d   = occ_q - OCC_ONE;
          state_d = S_EMIT;
        end
      end
      S_SU_WR: begin
        wr_en   = 1'b1;
        idx_d   = idx_inc;
        state_d = S_SU_CHK;
      end
      S_LIST_RD: begin
        state_d = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        // Read address is held here, so the read data stays put while stalled.
        if (slot_free) begin
          load_out = 1'b1;
          out_d    = '{status: ST_LISTED, id: rd_data.id, prio: rd_data.prio,
                       payload: rd_data.payload, last: (idx_inc == occ_q)};
          if (idx_inc == occ_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_inc;
            state_d = S_LIST_RD;
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    idx_q       <= idx_d;
    pos_q       <= pos_d;
    pos_found_q <= pos_found_d;
    st_q        <= st_d;
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.out_id       = out_q.id;
  assign rsp_o.out_priority = out_q.prio;
  assign rsp_o.out_payload  = out_q.payload;
  assign rsp_o.last         = out_q.last;

  // The occupancy count never passes the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) occ_q <= OCC_FULL)
    else $error("occupancy beyond depth");

  // Occupancy moves by at most one entry per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q != $past(occ_q)) |->
      ((occ_q == $past(occ_q) + OCC_ONE) || (occ_q + OCC_ONE == $past(occ_q))))
    else $error("occupancy jumped");

  // The scan only ever looks at occupied slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_CHK) |-> (idx_q < occ_q))
    else $error("scan beyond occupied slots");

  // Only listed entries can be followed by further results of the same request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.last) |-> (out_q.status == ST_LISTED))
    else $error("non-final result that is not a listed entry");

endmodule
